[hdl/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define KF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");

// two conditions that must never be true together
`define KF_NEVER(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !((a) && (b))) \
		else $error("%m: exclusive conditions met");

`endif

[hdl/kfpc_pkg.sv]
package kfpc_pkg;

	localparam int ACC_W = 56;
	localparam int DIV_STEPS = 48;
	localparam int Q_ONE = 65536;

	localparam int IN_TDATA_W = 40;
	localparam int IN_TUSER_W = 6;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD_W = OUT_TDATA_W - 34;

	localparam int DEF_STATE_DIM = 4;
	localparam int DEF_MEAS_DIM = 2;
	localparam int DEF_CTRL_DIM = 2;

	typedef logic signed [31:0] q_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef enum logic [1:0] {
		ACT_WMAT = 2'd0,
		ACT_WVEC = 2'd1,
		ACT_PRED = 2'd2,
		ACT_CORR = 2'd3
	} act_t;

	typedef enum logic [3:0] {
		TGT_TRANS = 4'd0,
		TGT_PNOISE = 4'd1,
		TGT_MEAS = 4'd2,
		TGT_MNOISE = 4'd3,
		TGT_CTRLM = 4'd4,
		TGT_COV = 4'd5,
		TGT_STATE = 4'd6,
		TGT_CTRLV = 4'd7,
		TGT_MEASV = 4'd8
	} tgt_t;

	// sign extend a q16.16 value to accumulator width
	function automatic acc_t ext(input q_t v);
		return {{(ACC_W-32){v[31]}}, v};
	endfunction

	// round a raw 64-bit product back to q16.16, ties toward plus infinity
	function automatic acc_t qrnd(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = (p + 64'sd32768) >>> 16;
		return t[ACC_W-1:0];
	endfunction

	// clamp to the signed 32-bit range
	function automatic q_t sat32(input acc_t v);
		if (&v[ACC_W-1:31] || ~|v[ACC_W-1:31]) begin
			return v[31:0];
		end else if (v[ACC_W-1]) begin
			return 32'sh8000_0000;
		end else begin
			return 32'sh7fff_ffff;
		end
	endfunction

	// magnitude as unsigned, exact for the most negative value
	function automatic logic [31:0] mag(input q_t v);
		return v[31] ? 32'(-v) : v;
	endfunction

endpackage

[hdl/kalman_filter_predict_correct.sv]
// channel  | dir | tdata (low bit up)                              | tuser         | tlast
// s_axis   | in  | row[1:0] col[3:2] entry_value[35:4] use_ctl[36] | action,target | -
// m_axis   | out | elem_index[1:0] elem_value[33:2]                | singular      | last
//
// write items are stored directly from idle; predict and correct run on the one shared
// 32x32 multiply-accumulate unit, and correct also on the one-bit-a-step divider
// arst_n clears all matrices and vectors to their reset values at once
// no item is taken while a job runs; the state vector is then offered one element a
// cycle and a stalled output holds its element until taken
module kalman_filter_predict_correct import kfpc_pkg::*; #(
	parameter int STATE_DIM = DEF_STATE_DIM,
	parameter int MEAS_DIM = DEF_MEAS_DIM,
	parameter int CTRL_DIM = DEF_CTRL_DIM
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // row, col, entry_value, use_control
	input  logic [IN_TUSER_W-1:0]  s_tuser,  // action, target
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // elem_index, elem_value
	output logic                   m_tlast,
	output logic                   m_tuser   // singular
);

	localparam int CS = (CTRL_DIM > 0) ? CTRL_DIM : 1;
	localparam int SW = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
	localparam int MW = (MEAS_DIM > 1) ? $clog2(MEAS_DIM) : 1;
	localparam int CWI = (CS > 1) ? $clog2(CS) : 1;
	localparam int CW = $clog2(STATE_DIM + MEAS_DIM + CTRL_DIM + 1);

	typedef enum logic [4:0] {
		IDLE, P_SX, P_TMP, P_COV, P_CPY,
		C_HP, C_S, E_PIV, E_CHK, E_DLD, E_DIV, E_DWB, E_ROW, E_ELM,
		C_HX, C_XP, C_CP, S_CPY, EMIT
	} st_t;

	typedef enum logic [1:0] {M_INIT, M_MUL, M_FIN, M_WB} mst_t;

	// model storage
	q_t a_q [STATE_DIM][STATE_DIM];
	q_t qn_q [STATE_DIM][STATE_DIM];
	q_t h_q [MEAS_DIM][STATE_DIM];
	q_t r_q [MEAS_DIM][MEAS_DIM];
	q_t b_q [STATE_DIM][CS];
	q_t xpr_q [STATE_DIM];
	q_t xpo_q [STATE_DIM];
	q_t ppr_q [STATE_DIM][STATE_DIM];
	q_t ppo_q [STATE_DIM][STATE_DIM];
	q_t u_q [CS];
	q_t z_q [MEAS_DIM];

	// scratch of one job
	q_t tmp_q [STATE_DIM][STATE_DIM];
	q_t hp_q [MEAS_DIM][STATE_DIM];
	q_t s_q [MEAS_DIM][MEAS_DIM];
	q_t x_q [MEAS_DIM][STATE_DIM];
	q_t inn_q [MEAS_DIM];

	st_t state_q;
	mst_t mstep_q;
	logic [CW-1:0] i_q, j_q, k_q;
	logic [MW-1:0] kk_q, best_q;
	logic use_ctrl_q, sing_q, pv_q;
	logic signed [63:0] prod_q;
	acc_t acc_q;
	q_t f_q, piv_q;

	// divider
	logic [47:0] num_q;
	logic [31:0] rem_q, den_q;
	logic dneg_q;
	logic [5:0] dcnt_q;

	// input fields
	act_t in_act;
	tgt_t in_tgt;
	logic [1:0] in_row, in_col;
	q_t in_val;
	logic in_use;

	assign in_act = act_t'(s_tuser[1:0]);
	assign in_tgt = tgt_t'(s_tuser[5:2]);
	assign in_row = s_tdata[1:0];
	assign in_col = s_tdata[3:2];
	assign in_val = s_tdata[35:4];
	assign in_use = s_tdata[36];

	// index views of the loop counters
	logic [SW-1:0] i_s, j_s, k_s, jx_s, row_s, col_s;
	logic [MW-1:0] i_m, j_m, k_m, row_m, col_m;
	logic [CWI-1:0] kc, row_c, col_c;
	logic j_in_s;

	assign i_s = SW'(i_q);
	assign j_s = SW'(j_q);
	assign k_s = SW'(k_q);
	assign jx_s = SW'(j_q - CW'(MEAS_DIM));
	assign i_m = MW'(i_q);
	assign j_m = MW'(j_q);
	assign k_m = MW'(k_q);
	assign kc = CWI'(k_q - CW'(STATE_DIM));
	assign row_s = SW'(in_row);
	assign col_s = SW'(in_col);
	assign row_m = MW'(in_row);
	assign col_m = MW'(in_col);
	assign row_c = CWI'(in_row);
	assign col_c = CWI'(in_col);
	// elimination columns run over s first, then over x
	assign j_in_s = j_q < CW'(MEAS_DIM);

	logic row_ok_n, col_ok_n, row_ok_m, col_ok_m, row_ok_c, col_ok_c;
	assign row_ok_n = 32'(in_row) < STATE_DIM;
	assign col_ok_n = 32'(in_col) < STATE_DIM;
	assign row_ok_m = 32'(in_row) < MEAS_DIM;
	assign col_ok_m = 32'(in_col) < MEAS_DIM;
	assign row_ok_c = 32'(in_row) < CTRL_DIM;
	assign col_ok_c = 32'(in_col) < CTRL_DIM;

	// operand selection for the shared multiply-accumulate unit
	q_t op_a, op_b, init_v, rowk_v;
	logic neg;
	logic [CW-1:0] klast, ilast, jlast;

	assign rowk_v = j_in_s ? s_q[kk_q][j_m] : x_q[kk_q][jx_s];

	always_comb begin
		op_a = '0;
		op_b = '0;
		init_v = '0;
		neg = 1'b0;
		klast = '0;
		ilast = '0;
		jlast = '0;
		case (state_q)
			P_SX: begin
				if (k_q < CW'(STATE_DIM)) begin
					op_a = a_q[i_s][k_s];
					op_b = xpo_q[k_s];
				end else begin
					op_a = b_q[i_s][kc];
					op_b = u_q[kc];
				end
				klast = (use_ctrl_q && CTRL_DIM > 0) ? CW'(STATE_DIM + CTRL_DIM - 1)
					: CW'(STATE_DIM - 1);
				ilast = CW'(STATE_DIM - 1);
			end
			P_TMP: begin
				op_a = a_q[i_s][k_s];
				op_b = ppo_q[k_s][j_s];
				klast = CW'(STATE_DIM - 1);
				ilast = CW'(STATE_DIM - 1);
				jlast = CW'(STATE_DIM - 1);
			end
			P_COV: begin
				op_a = tmp_q[i_s][k_s];
				op_b = a_q[j_s][k_s];
				init_v = qn_q[i_s][j_s];
				klast = CW'(STATE_DIM - 1);
				ilast = CW'(STATE_DIM - 1);
				jlast = CW'(STATE_DIM - 1);
			end
			C_HP: begin
				op_a = h_q[i_m][k_s];
				op_b = ppr_q[k_s][j_s];
				klast = CW'(STATE_DIM - 1);
				ilast = CW'(MEAS_DIM - 1);
				jlast = CW'(STATE_DIM - 1);
			end
			C_S: begin
				op_a = hp_q[i_m][k_s];
				op_b = h_q[j_m][k_s];
				init_v = r_q[i_m][j_m];
				klast = CW'(STATE_DIM - 1);
				ilast = CW'(MEAS_DIM - 1);
				jlast = CW'(MEAS_DIM - 1);
			end
			E_ELM: begin
				// row r minus factor times pivot row, one term each
				op_a = f_q;
				op_b = rowk_v;
				init_v = j_in_s ? s_q[i_m][j_m] : x_q[i_m][jx_s];
				neg = 1'b1;
				jlast = CW'(MEAS_DIM + STATE_DIM - 1);
			end
			C_HX: begin
				op_a = h_q[i_m][k_s];
				op_b = xpr_q[k_s];
				klast = CW'(STATE_DIM - 1);
				ilast = CW'(MEAS_DIM - 1);
			end
			C_XP: begin
				op_a = x_q[k_m][i_s];
				op_b = inn_q[k_m];
				init_v = xpr_q[i_s];
				klast = CW'(MEAS_DIM - 1);
				ilast = CW'(STATE_DIM - 1);
			end
			C_CP: begin
				op_a = x_q[k_m][i_s];
				op_b = hp_q[k_m][j_s];
				init_v = ppr_q[i_s][j_s];
				neg = 1'b1;
				klast = CW'(MEAS_DIM - 1);
				ilast = CW'(STATE_DIM - 1);
				jlast = CW'(STATE_DIM - 1);
			end
			default: begin
			end
		endcase
	end

	logic signed [63:0] mul;
	acc_t term, acc_sum;
	q_t res;

	assign mul = op_a * op_b;
	assign term = neg ? -qrnd(prod_q) : qrnd(prod_q);
	assign acc_sum = acc_q + term;
	assign res = sat32(acc_q);

	// innovation z - h*x, clamped twice as the filter defines it
	logic signed [32:0] idiff;
	q_t inn_v;
	logic [MW-1:0] inn_idx;

	assign inn_idx = i_m;
	assign idiff = {z_q[inn_idx][31], z_q[inn_idx]} - {res[31], res};
	assign inn_v = (idiff[32] == idiff[31]) ? idiff[31:0]
		: (idiff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff);

	// restoring divider step and signed, clamped quotient
	logic [32:0] dtry;
	logic dge;
	q_t dres;

	assign dtry = {rem_q, num_q[47]};
	assign dge = dtry >= {1'b0, den_q};
	always_comb begin
		if (dneg_q) begin
			dres = (num_q > 48'h0000_8000_0000) ? 32'sh8000_0000 : 32'(-num_q[31:0]);
		end else begin
			dres = (num_q > 48'h0000_7fff_ffff) ? 32'sh7fff_ffff : num_q[31:0];
		end
	end

	// pivot search compares magnitudes down the current column
	logic piv_better;
	assign piv_better = mag(s_q[i_m][kk_q]) > mag(s_q[best_q][kk_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			mstep_q <= M_INIT;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			kk_q <= '0;
			best_q <= '0;
			use_ctrl_q <= 1'b0;
			sing_q <= 1'b0;
			pv_q <= 1'b0;
			prod_q <= '0;
			acc_q <= '0;
			f_q <= '0;
			piv_q <= '0;
			num_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			dneg_q <= 1'b0;
			dcnt_q <= '0;
			for (int r = 0; r < STATE_DIM; r++) begin
				xpr_q[r] <= '0;
				xpo_q[r] <= '0;
				for (int c = 0; c < STATE_DIM; c++) begin
					a_q[r][c] <= (r == c) ? 32'(Q_ONE) : '0;
					qn_q[r][c] <= (r == c) ? 32'(Q_ONE) : '0;
					ppr_q[r][c] <= '0;
					ppo_q[r][c] <= '0;
					tmp_q[r][c] <= '0;
				end
				for (int c = 0; c < CS; c++) begin
					b_q[r][c] <= '0;
				end
			end
			for (int r = 0; r < MEAS_DIM; r++) begin
				z_q[r] <= '0;
				inn_q[r] <= '0;
				for (int c = 0; c < STATE_DIM; c++) begin
					h_q[r][c] <= '0;
					hp_q[r][c] <= '0;
					x_q[r][c] <= '0;
				end
				for (int c = 0; c < MEAS_DIM; c++) begin
					r_q[r][c] <= (r == c) ? 32'(Q_ONE) : '0;
					s_q[r][c] <= '0;
				end
			end
			for (int r = 0; r < CS; r++) begin
				u_q[r] <= '0;
			end
		end else begin
			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						i_q <= '0;
						j_q <= '0;
						mstep_q <= M_INIT;
						case (in_act)
							ACT_WMAT: begin
								case (in_tgt)
									TGT_TRANS: if (row_ok_n && col_ok_n) a_q[row_s][col_s] <= in_val;
									TGT_PNOISE: if (row_ok_n && col_ok_n) qn_q[row_s][col_s] <= in_val;
									TGT_MEAS: if (row_ok_m && col_ok_n) h_q[row_m][col_s] <= in_val;
									TGT_MNOISE: if (row_ok_m && col_ok_m) r_q[row_m][col_m] <= in_val;
									TGT_CTRLM: if (row_ok_n && col_ok_c) b_q[row_s][col_c] <= in_val;
									TGT_COV: if (row_ok_n && col_ok_n) ppo_q[row_s][col_s] <= in_val;
									default: begin
									end
								endcase
							end
							ACT_WVEC: begin
								case (in_tgt)
									TGT_STATE: if (row_ok_n) xpo_q[row_s] <= in_val;
									TGT_CTRLV: if (row_ok_c) u_q[row_c] <= in_val;
									TGT_MEASV: if (row_ok_m) z_q[row_m] <= in_val;
									default: begin
									end
								endcase
							end
							ACT_PRED: begin
								use_ctrl_q <= in_use;
								sing_q <= 1'b0;
								state_q <= P_SX;
							end
							ACT_CORR: begin
								sing_q <= 1'b0;
								state_q <= C_HP;
							end
							default: begin
							end
						endcase
					end
				end
				P_SX, P_TMP, P_COV, C_HP, C_S, E_ELM, C_HX, C_XP, C_CP: begin
					case (mstep_q)
						M_INIT: begin
							acc_q <= ext(init_v);
							k_q <= '0;
							pv_q <= 1'b0;
							mstep_q <= M_MUL;
						end
						M_MUL: begin
							// product is registered and summed into the accumulator in the cycle after
							prod_q <= mul;
							pv_q <= 1'b1;
							if (pv_q) acc_q <= acc_sum;
							k_q <= k_q + 1'b1;
							if (k_q == klast) mstep_q <= M_FIN;
						end
						M_FIN: begin
							acc_q <= acc_sum;
							mstep_q <= M_WB;
						end
						M_WB: begin
							mstep_q <= M_INIT;
							case (state_q)
								P_SX: xpr_q[i_s] <= res;
								P_TMP: tmp_q[i_s][j_s] <= res;
								P_COV: begin
									ppr_q[i_s][j_s] <= res;
									ppo_q[i_s][j_s] <= res;
								end
								C_HP: begin
									hp_q[i_m][j_s] <= res;
									x_q[i_m][j_s] <= res;
								end
								C_S: s_q[i_m][j_m] <= res;
								E_ELM: begin
									if (j_in_s) s_q[i_m][j_m] <= res;
									else x_q[i_m][jx_s] <= res;
								end
								C_HX: inn_q[i_m] <= inn_v;
								C_XP: xpo_q[i_s] <= res;
								C_CP: ppo_q[i_s][j_s] <= res;
								default: begin
								end
							endcase
							if (state_q == E_ELM) begin
								if (j_q == jlast) begin
									j_q <= '0;
									i_q <= i_q + 1'b1;
									state_q <= E_ROW;
								end else begin
									j_q <= j_q + 1'b1;
								end
							end else if (j_q != jlast) begin
								j_q <= j_q + 1'b1;
							end else if (i_q != ilast) begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end else begin
								j_q <= '0;
								i_q <= '0;
								case (state_q)
									P_SX: state_q <= P_TMP;
									P_TMP: state_q <= P_COV;
									P_COV: state_q <= P_CPY;
									C_HP: state_q <= C_S;
									C_S: begin
										kk_q <= '0;
										best_q <= '0;
										state_q <= E_PIV;
									end
									C_HX: state_q <= C_XP;
									C_XP: state_q <= C_CP;
									default: state_q <= EMIT;
								endcase
							end
						end
						default: mstep_q <= M_INIT;
					endcase
				end
				P_CPY: begin
					xpo_q[i_s] <= xpr_q[i_s];
					if (i_q == CW'(STATE_DIM - 1)) begin
						i_q <= '0;
						state_q <= EMIT;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				E_PIV: begin
					// first row of largest magnitude wins
					if (i_q < CW'(MEAS_DIM)) begin
						if (piv_better) best_q <= i_m;
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= E_CHK;
					end
				end
				E_CHK: begin
					if (s_q[best_q][kk_q] == '0) begin
						// singular: gain taken as zero
						sing_q <= 1'b1;
						i_q <= '0;
						j_q <= '0;
						state_q <= S_CPY;
					end else begin
						if (best_q != kk_q) begin
							for (int c = 0; c < MEAS_DIM; c++) begin
								s_q[kk_q][c] <= s_q[best_q][c];
								s_q[best_q][c] <= s_q[kk_q][c];
							end
							for (int c = 0; c < STATE_DIM; c++) begin
								x_q[kk_q][c] <= x_q[best_q][c];
								x_q[best_q][c] <= x_q[kk_q][c];
							end
						end
						piv_q <= s_q[best_q][kk_q];
						j_q <= '0;
						state_q <= E_DLD;
					end
				end
				E_DLD: begin
					num_q <= {mag(rowk_v), 16'h0000};
					den_q <= mag(piv_q);
					rem_q <= '0;
					dneg_q <= rowk_v[31] ^ piv_q[31];
					dcnt_q <= '0;
					state_q <= E_DIV;
				end
				E_DIV: begin
					rem_q <= dge ? 32'(dtry - {1'b0, den_q}) : dtry[31:0];
					num_q <= {num_q[46:0], dge};
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 6'(DIV_STEPS - 1)) state_q <= E_DWB;
				end
				E_DWB: begin
					if (j_in_s) s_q[kk_q][j_m] <= dres;
					else x_q[kk_q][jx_s] <= dres;
					if (j_q == CW'(MEAS_DIM + STATE_DIM - 1)) begin
						j_q <= '0;
						i_q <= '0;
						state_q <= E_ROW;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= E_DLD;
					end
				end
				E_ROW: begin
					if (i_q == CW'(MEAS_DIM)) begin
						if (kk_q == MW'(MEAS_DIM - 1)) begin
							i_q <= '0;
							j_q <= '0;
							mstep_q <= M_INIT;
							state_q <= C_HX;
						end else begin
							kk_q <= kk_q + 1'b1;
							best_q <= kk_q + 1'b1;
							i_q <= CW'(kk_q) + 1'b1;
							state_q <= E_PIV;
						end
					end else if (i_m == kk_q) begin
						i_q <= i_q + 1'b1;
					end else begin
						// factor latched before the row changes under it
						f_q <= s_q[i_m][kk_q];
						j_q <= '0;
						mstep_q <= M_INIT;
						state_q <= E_ELM;
					end
				end
				S_CPY: begin
					ppo_q[i_s][j_s] <= ppr_q[i_s][j_s];
					if (j_q == '0) xpo_q[i_s] <= xpr_q[i_s];
					if (j_q != CW'(STATE_DIM - 1)) begin
						j_q <= j_q + 1'b1;
					end else if (i_q != CW'(STATE_DIM - 1)) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= '0;
						i_q <= '0;
						state_q <= EMIT;
					end
				end
				EMIT: begin
					if (m_tready) begin
						if (i_q == CW'(STATE_DIM - 1)) begin
							i_q <= '0;
							state_q <= IDLE;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = (state_q == EMIT);
	assign m_tdata = {{OUT_PAD_W{1'b0}}, xpo_q[i_s], 2'(i_q)};
	assign m_tlast = (i_q == CW'(STATE_DIM - 1));
	assign m_tuser = sing_q;

endmodule

[hdl/kfpc_chk.sv]
`include "assert_macros.svh"

module kfpc_chk import kfpc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tlast,
	input logic                   m_tuser
);

	// no item is taken while the state vector goes out
	`KF_NEVER(a_busy_excl, s_tready, m_tvalid)

	`KF_ASSERT(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

	// a vector ends with its last element and the block goes idle
	`KF_ASSERT(a_last_gap, (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)

	// elements follow in index order without gaps
	`KF_ASSERT(a_index_step, (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1))

	// the singular flag is the same on every element of a vector
	`KF_ASSERT(a_flag_stable, (m_tvalid && m_tready && !m_tlast) |=> $stable(m_tuser))

endmodule

bind kalman_filter_predict_correct kfpc_chk u_kfpc_chk (.*);
